[src/ctb_pkg.sv]
// Shared constants, types and codes for the columnar transposition block.
package ctb_pkg;

  localparam int BLOCK_BYTES   = 1024;
  localparam int MAX_KEY_CHARS = 16;
  localparam int REG_KEY_CHARS = 16;
  localparam int KEY_LIMIT     = (MAX_KEY_CHARS < REG_KEY_CHARS) ? MAX_KEY_CHARS
                                                                 : REG_KEY_CHARS;

  localparam int POS_W     = 10;
  localparam int BYTE_W    = 8;
  localparam int KLEN_W    = 5;
  localparam int KEYREG_W  = 64;
  localparam int CFG_IDX_W = 2;

  localparam int ADDR_W = $clog2(BLOCK_BYTES);
  localparam int DIV_W  = ADDR_W + 1;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int CS_W   = $clog2(KEY_LIMIT);
  localparam int CI_W   = $clog2(MAX_KEY_CHARS);
  localparam int PROD_W = DIV_W + KLEN_W;

  localparam logic [KLEN_W-1:0]   KEY_LENGTH_RESET = 5'd8;
  localparam logic [KEYREG_W-1:0] KEY_LOW_RESET    = 64'h74616B656A6F7270;
  localparam logic [KEYREG_W-1:0] KEY_HIGH_RESET   = 64'h0;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [2:0] {
    S_RANK_START,
    S_RANK,
    S_ROWS,
    S_IDLE,
    S_DIV,
    S_RD,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic rank_clear;
    logic rank_step;
    logic div_start;
    logic div_rows;
    logic rows_load;
    logic take_write;
    logic take_read;
    logic addr_load;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic rank_last;
    logic div_done;
    logic out_busy;
    logic in_valid;
    logic in_func;
  } stat_t;

endpackage

[src/ctb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ctb_div.sv]
// Restoring divider, one quotient bit per cycle.
module ctb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ctb_pkg::DIV_W-1:0] dividend,
  input  logic [ctb_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ctb_pkg::DIV_W-1:0] quotient,
  output logic [ctb_pkg::DIV_W-1:0] remainder
);
  import ctb_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DCNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done      = !busy;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

[src/ctb_datapath.sv]
// Datapath: key registers, column ranking, divider, block store and output register.
module ctb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ctb_pkg::cmd_t                 cmd,
  output ctb_pkg::stat_t                stat,
  input  logic                          in_valid,
  input  logic                          func,
  input  logic [ctb_pkg::POS_W-1:0]     position,
  input  logic [ctb_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctb_pkg::BYTE_W-1:0]    result_byte,
  input  logic                          cfg_we,
  input  logic [ctb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctb_pkg::KEYREG_W-1:0]  cfg_data
);
  import ctb_pkg::*;

  logic [KLEN_W-1:0]   key_length;
  logic [KEYREG_W-1:0] key_low;
  logic [KEYREG_W-1:0] key_high;
  logic [2*KEYREG_W-1:0] key_all;
  logic [KLEN_W-1:0]   k;
  logic [7:0]          key_char [KEY_LIMIT];
  logic [7:0]          cp;
  logic [KEY_LIMIT-1:0] hit;
  logic [CI_W-1:0]     rank_idx;
  logic [KLEN_W-1:0]   rank_p;
  logic [CS_W-1:0]     column_start [MAX_KEY_CHARS];

  logic [DIV_W-1:0]    rows;
  logic                div_start;
  logic [DIV_W-1:0]    div_a;
  logic [DIV_W-1:0]    div_b;
  logic                div_done;
  logic [DIV_W-1:0]    quo;
  logic [DIV_W-1:0]    rem;

  logic                pos_ok;
  logic [ADDR_W-1:0]   pos_q;
  logic                zero_q;
  logic [CS_W-1:0]     col_q;
  logic [PROD_W-1:0]   prod_q;
  logic                in_range_q;
  logic [PROD_W-1:0]   src_wide;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LENGTH_RESET;
      key_low    <= KEY_LOW_RESET;
      key_high   <= KEY_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LENGTH: key_length <= cfg_data[KLEN_W-1:0];
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_KEY_HIGH:   key_high   <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    if (key_length == '0) begin
      k = KLEN_W'(1);
    end else if (key_length > KLEN_W'(KEY_LIMIT)) begin
      k = KLEN_W'(KEY_LIMIT);
    end else begin
      k = key_length;
    end
  end

  assign key_all = {key_high, key_low};

  always_comb begin
    for (int i = 0; i < KEY_LIMIT; i++) begin
      key_char[i] = key_all[8*i +: 8];
    end
  end

  // rank of key character rank_p; ties go to the lower position
  assign cp = key_char[rank_p[CS_W-1:0]];

  always_comb begin
    for (int q = 0; q < KEY_LIMIT; q++) begin
      hit[q] = (KLEN_W'(q) < k) &&
               ((key_char[q] < cp) || ((key_char[q] == cp) && (KLEN_W'(q) < rank_p)));
    end
  end

  assign rank_idx = CI_W'($countones(hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_p <= '0;
    end else if (cmd.rank_clear) begin
      rank_p <= '0;
    end else if (cmd.rank_step) begin
      rank_p <= rank_p + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rank_step) begin
      column_start[rank_idx] <= rank_p[CS_W-1:0];
    end
  end

  // divider: rows = block / k during ranking, position / rows for reads
  assign div_start = cmd.div_start | cmd.take_read;
  assign div_a     = cmd.div_rows ? DIV_W'(BLOCK_BYTES) : DIV_W'(position);
  assign div_b     = cmd.div_rows ? DIV_W'(k) : rows;

  ctb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.rows_load) begin
      rows <= quo;
    end
  end

  assign pos_ok = (32'(position) < 32'(BLOCK_BYTES));

  always_ff @(posedge clk) begin
    if (cmd.take_read) begin
      pos_q  <= ADDR_W'(position);
      zero_q <= !pos_ok;
    end
    if (cmd.addr_load) begin
      col_q      <= column_start[quo[CI_W-1:0]];
      prod_q     <= PROD_W'(rem) * PROD_W'(k);
      in_range_q <= (quo < DIV_W'(k));
    end
  end

  assign src_wide = PROD_W'(col_q) + prod_q;
  assign rd_addr  = (in_range_q && (src_wide < PROD_W'(BLOCK_BYTES))) ?
                    src_wide[ADDR_W-1:0] : pos_q;

  ctb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BLOCK_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take_write && pos_ok),
    .waddr (ADDR_W'(position)),
    .wdata (data_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_byte <= zero_q ? '0 : rd_data;
    end
  end

  always_comb begin
    stat.cfg_wr    = cfg_we;
    stat.rank_last = (rank_p == k - 1'b1);
    stat.div_done  = div_done;
    stat.out_busy  = out_valid && !out_ready;
    stat.in_valid  = in_valid;
    stat.in_func   = func;
  end

endmodule

[src/ctb_ctrl.sv]
// Controller: ranking pass, request sequencing and output handoff.
module ctb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  ctb_pkg::stat_t stat,
  output ctb_pkg::cmd_t  cmd,
  output logic           in_ready
);
  import ctb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RANK_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (stat.cfg_wr) begin
      state_next = S_RANK_START;
    end else begin
      case (state)
        S_RANK_START: state_next = S_RANK;
        S_RANK:       if (stat.rank_last) state_next = S_ROWS;
        S_ROWS:       if (stat.div_done) state_next = S_IDLE;
        S_IDLE:       if (stat.in_valid && stat.in_func == FUNC_READ) state_next = S_DIV;
        S_DIV:        if (stat.div_done) state_next = S_RD;
        S_RD:         state_next = S_LOAD;
        S_LOAD:       if (!stat.out_busy) state_next = S_IDLE;
        default:      state_next = S_RANK_START;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_RANK_START: begin
        cmd.rank_clear = 1'b1;
        cmd.div_start  = 1'b1;
        cmd.div_rows   = 1'b1;
      end
      S_RANK: begin
        cmd.rank_step = 1'b1;
      end
      S_ROWS: begin
        cmd.rows_load = stat.div_done;
      end
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.take_write = stat.in_valid && (stat.in_func == FUNC_STORE);
        cmd.take_read  = stat.in_valid && (stat.in_func == FUNC_READ);
      end
      S_DIV: begin
        cmd.addr_load = stat.div_done;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
      end
      S_LOAD: begin
        cmd.out_load = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

[src/columnar_transposition_block.sv]
// Top level: keyed columnar transposition over a 1024-byte block store.
// Store requests are written straight into the block store. A read request runs through S_DIV,
// where the bit-per-cycle divider forms position / rows, then S_RD and S_LOAD, which waits
// while a stalled result is held; the next request is taken the cycle after the result is loaded.
// Reset (synchronous, active high) loads the default key; the ranking pass overlaps the rows
// division, and requests wait until both are done; every configuration write restarts
// that pass. The block store is not cleared.
module columnar_transposition_block (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [ctb_pkg::POS_W-1:0]     position,
  input  logic [ctb_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctb_pkg::BYTE_W-1:0]    result_byte,
  input  logic                          cfg_we,
  input  logic [ctb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctb_pkg::KEYREG_W-1:0]  cfg_data
);
  import ctb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  ctb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_valid    (in_valid),
    .func        (func),
    .position    (position),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_byte (result_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

[src/ctb_checker.sv]
// Port-level checker for the columnar transposition block, bound to the top level.
module ctb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ctb_pkg::BYTE_W-1:0]    result_byte,
  input logic                          cfg_we
);
  import ctb_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_byte))
    else $error("result changed while stalled");

  // a store request never produces a result
  a_store_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_STORE && !out_valid |=> !out_valid)
    else $error("result appeared after store request");

  // one read request at a time
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_READ |=> !in_ready)
    else $error("request taken while read in flight");

  // ranking pass after reset
  a_reset_rank: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("request taken before ranking pass");

  // configuration write restarts ranking
  a_cfg_rank: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("request taken right after configuration write");

endmodule

bind columnar_transposition_block ctb_checker u_checker (.*);

[bench/columnar_transposition_block_test.sv]
// Self-checking testbench for the columnar transposition block: directed table, then random.
`timescale 1ns / 100ps

module columnar_transposition_block_test;
  import ctb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 48;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 95;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [KEYREG_W-1:0]   val;
    logic                  f;
    logic [POS_W-1:0]      pos;
    logic [BYTE_W-1:0]     data;
    bit                    typed;
    logic [BYTE_W-1:0]     exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = FUNC_STORE;
  logic [POS_W-1:0]      position = '0;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     result_byte;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_LENGTH;
  logic [KEYREG_W-1:0]   cfg_data = '0;

  // mirror of the block: key registers, column ranks and byte store
  logic [KLEN_W-1:0]     key_len_q = KEY_LENGTH_RESET;
  logic [KEYREG_W-1:0]   key_lo_q  = KEY_LOW_RESET;
  logic [KEYREG_W-1:0]   key_hi_q  = KEY_HIGH_RESET;
  int unsigned           col_start_model [MAX_KEY_CHARS];
  logic [BYTE_W-1:0]     block_image [BLOCK_BYTES];
  bit                    image_written [BLOCK_BYTES];

  logic [BYTE_W-1:0]     pending_bytes [$];
  dir_row_t              dir_rows [$];
  int                    failures = 0;
  int                    cycle_count = 0;
  int                    items_sent = 0;
  int                    burst_left = 0;
  bit                    no_gaps = 1'b0;
  int unsigned           rcv_cycle = 0;
  int                    rcv_mode = 0;

  columnar_transposition_block DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .position(position), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .result_byte(result_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern, draws a new mode whenever the low byte of rcv_cycle is zero
  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    if (rcv_cycle[7:0] == 8'd0) rcv_mode <= $urandom_range(0, 3);
    case (rcv_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rcv_cycle % 5 == 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %02h", $time, result_byte);
        failures++;
      end else begin
        if (result_byte !== pending_bytes[0]) begin
          $display("%0t: result_byte mismatch, expected %02h, actual %02h",
                   $time, pending_bytes[0], result_byte);
          failures++;
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  function automatic int unsigned eff_key_len();
    int unsigned k;
    k = 32'(key_len_q);
    if (k == 0) k = 1;
    if (k > KEY_LIMIT) k = KEY_LIMIT;
    return k;
  endfunction

  function automatic logic [7:0] key_char(int unsigned p);
    if (p < 8) return key_lo_q[8*p +: 8];
    return key_hi_q[8*(p-8) +: 8];
  endfunction

  function automatic void rank_key_columns();
    int unsigned k, rank;
    logic [7:0] cp, cq;
    k = eff_key_len();
    foreach (col_start_model[i]) col_start_model[i] = 0;
    for (int unsigned p = 0; p < k; p++) begin
      cp = key_char(p);
      rank = 0;
      for (int unsigned q = 0; q < k; q++) begin
        cq = key_char(q);
        if (cq < cp || (cq == cp && q < p)) rank++;
      end
      col_start_model[rank] = p;
    end
  endfunction

  function automatic int unsigned source_of(logic [POS_W-1:0] pos);
    int unsigned k, rows, src;
    k = eff_key_len();
    rows = BLOCK_BYTES / k;
    if (pos < k * rows) src = col_start_model[pos / rows] + (pos % rows) * k;
    else src = 32'(pos);
    if (src >= BLOCK_BYTES) src = 32'(pos);
    return src;
  endfunction

  function automatic logic [63:0] random_key_word();
    logic [63:0] w;
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: w = {$urandom, $urandom};
      1: for (int i = 0; i < 8; i++) w[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 2));
      2: begin
        b = 8'($urandom);
        w = {8{b}};
      end
      3: w = '0;
      default: w = '1;
    endcase
    return w;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [KEYREG_W-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t req_row(logic f, logic [POS_W-1:0] pos, logic [BYTE_W-1:0] data,
                                       bit typed, logic [BYTE_W-1:0] exp);
    dir_row_t r;
    r = '{default: '0};
    r.f = f;
    r.pos = pos;
    r.data = data;
    r.typed = typed;
    r.exp = exp;
    return r;
  endfunction

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [KEYREG_W-1:0] val);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_LENGTH: key_len_q = val[KLEN_W-1:0];
      REG_KEY_LOW:    key_lo_q = val;
      REG_KEY_HIGH:   key_hi_q = val;
      default: ;
    endcase
    if (idx != REG_UNUSED) rank_key_columns();
  endtask

  // returns at the edge where the request was taken, valid still high
  task automatic drive_request(logic f, logic [POS_W-1:0] pos, logic [BYTE_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    position <= pos;
    data_byte <= data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic issue_store(logic [POS_W-1:0] pos, logic [BYTE_W-1:0] data);
    drive_request(FUNC_STORE, pos, data);
    block_image[pos] = data;
    image_written[pos] = 1'b1;
  endtask

  task automatic issue_read(logic [POS_W-1:0] pos, bit typed, logic [BYTE_W-1:0] exp);
    int unsigned src;
    src = source_of(pos);
    if (!typed && !image_written[src]) issue_store(POS_W'(src), BYTE_W'($urandom));
    drive_request(FUNC_READ, pos, BYTE_W'($urandom));
    pending_bytes.push_back(typed ? exp : block_image[src]);
  endtask

  initial begin
    int phase_base;
    bit paused;
    logic [POS_W-1:0] pos;
    logic [KLEN_W-1:0] len;

    foreach (image_written[i]) image_written[i] = 1'b0;
    rank_key_columns();

    // default key ranks: a e j k o p r t -> starts 6 4 3 5 2 0 1 7, 128 rows
    dir_rows.push_back(req_row(FUNC_STORE, 10'd6, 8'hA5, 0, 0));
    dir_rows.push_back(req_row(FUNC_STORE, 10'd1023, 8'hFF, 0, 0));
    dir_rows.push_back(req_row(FUNC_STORE, 10'd4, 8'h00, 0, 0));
    dir_rows.push_back(req_row(FUNC_STORE, 10'd7, 8'h3C, 0, 0));
    dir_rows.push_back(req_row(FUNC_READ, 10'd0, 8'h00, 1, 8'hA5));
    dir_rows.push_back(req_row(FUNC_READ, 10'd1023, 8'hFF, 1, 8'hFF));
    dir_rows.push_back(req_row(FUNC_READ, 10'd128, 8'h5E, 1, 8'h00));
    dir_rows.push_back(req_row(FUNC_READ, 10'd896, 8'h00, 1, 8'h3C));
    // zero key length acts as one: identity
    dir_rows.push_back(cfg_row(REG_KEY_LENGTH, 64'd0));
    dir_rows.push_back(req_row(FUNC_READ, 10'd6, 8'h11, 1, 8'hA5));
    dir_rows.push_back(req_row(FUNC_READ, 10'd1023, 8'h00, 1, 8'hFF));
    // three columns leave position 1023 as an uncovered tail
    dir_rows.push_back(cfg_row(REG_KEY_LENGTH, 64'd3));
    dir_rows.push_back(req_row(FUNC_READ, 10'd1023, 8'h00, 1, 8'hFF));
    // oversize length clamps to 16; the eight zero chars rank first, in order
    dir_rows.push_back(cfg_row(REG_KEY_LENGTH, 64'd31));
    dir_rows.push_back(req_row(FUNC_STORE, 10'd8, 8'h5A, 0, 0));
    dir_rows.push_back(req_row(FUNC_STORE, 10'd9, 8'h81, 0, 0));
    dir_rows.push_back(req_row(FUNC_READ, 10'd0, 8'h00, 1, 8'h5A));
    dir_rows.push_back(req_row(FUNC_READ, 10'd64, 8'h00, 1, 8'h81));
    // unused register index changes nothing
    dir_rows.push_back(cfg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(req_row(FUNC_READ, 10'd0, 8'h00, 1, 8'h5A));
    dir_rows.push_back(cfg_row(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_KEY_LOW, 64'h0));
    dir_rows.push_back(req_row(FUNC_READ, 10'd0, 8'h00, 0, 0));
    dir_rows.push_back(req_row(FUNC_READ, 10'd1023, 8'hFF, 0, 0));
    dir_rows.push_back(req_row(FUNC_READ, 10'd512, 8'h00, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_register(dir_rows[i].idx, dir_rows[i].val);
      else if (dir_rows[i].f == FUNC_STORE) issue_store(dir_rows[i].pos, dir_rows[i].data);
      else issue_read(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].exp);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: len = 5'd1;
        1: len = 5'd16;
        default: begin
          case ($urandom_range(0, 5))
            0: len = 5'd0;
            1: len = KLEN_W'($urandom_range(17, 31));
            2: len = 5'd16;
            default: len = KLEN_W'($urandom_range(1, 16));
          endcase
        end
      endcase
      write_register(REG_KEY_LENGTH, {$urandom, $urandom} & ~64'h1F | 64'(len));
      write_register(REG_KEY_LOW, random_key_word());
      write_register(REG_KEY_HIGH, random_key_word());
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, {$urandom, $urandom});
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_base = items_sent;
      paused = 1'b0;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        if (!paused && (items_sent - phase_base >= PHASE_ITEMS / 2)) begin
          wait_results_done();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          0: pos = '0;
          1: pos = '1;
          default: pos = POS_W'($urandom);
        endcase
        if ($urandom_range(0, 9) < 4) issue_store(pos, BYTE_W'($urandom));
        else issue_read(pos, 0, 0);
      end
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
